// ===== rtl/core/gda_pkg.sv =====
// gda_pkg: shared types, status codes and calendar helpers for the date block
// used by gda_ctrl, gda_dpath and gregorian_date_add_and_difference
`timescale 1ns / 1ps

package gda_pkg;

    // internal year width, holds any year up to 131071
    localparam int YEAR_W = 17;
    // width of the remainder registers used for year mod 25
    localparam int REM_W = 14;
    // first step index of the mod 25 reduction (25 << 9 is the top subtrahend)
    localparam logic [3:0] RED_TOP = 4'd9;
    localparam logic [REM_W-1:0] MOD_BASE = 14'd25;

    // operation kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_DIFF = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_LATER    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // input transaction
    typedef struct packed {
        logic        kind;
        logic [4:0]  day_a;
        logic [3:0]  month_a;
        logic [13:0] year_a;
        logic [4:0]  day_b;
        logic [3:0]  month_b;
        logic [13:0] year_b;
        logic [21:0] count;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [4:0]  res_day;
        logic [3:0]  res_month;
        logic [13:0] res_year;
        logic [21:0] days_between;
        logic [1:0]  status;
    } t_out;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       reduce;
        logic       init_walk;
        logic       from_b;
        logic       step;
        logic       set_status;
        logic [1:0] status_code;
        logic       emit;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic kind;
        logic reduce_last;
        logic ok_a;
        logic ok_b;
        logic b_later;
        logic walk_end;
        logic over;
        logic out_free;
    } t_sts;

    // leap year from the low year bits and the year mod 25
    function automatic logic is_leap(input logic [3:0] ylow, input logic [4:0] y25);
        return (ylow[1:0] == 2'd0) && ((y25 != 5'd0) || (ylow == 4'd0));
    endfunction

    // days in a month, month codes outside 1..12 read as 31
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else if (m == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end
        return len;
    endfunction

endpackage

// ===== rtl/core/gda_ctrl.sv =====
// gda_ctrl: sequencing state machine for the date block
// depends on gda_pkg for the command, status and code definitions
`timescale 1ns / 1ps

module gda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  gda_pkg::t_sts i_sts,
    output gda_pkg::t_cmd o_cmd
);
    import gda_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // input side takes a transaction only while idle and out of reset
    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                if (i_sts.reduce_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.kind == KIND_ADD) begin
                    if (!i_sts.ok_a) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_INVALID;
                        n_state           = S_DONE;
                    end else begin
                        o_cmd.init_walk = 1'b1;
                        n_state         = S_WALK;
                    end
                end else begin
                    if (!i_sts.ok_a || !i_sts.ok_b) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_INVALID;
                        n_state           = S_DONE;
                    end else if (i_sts.b_later) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_LATER;
                        n_state           = S_DONE;
                    end else begin
                        o_cmd.init_walk = 1'b1;
                        o_cmd.from_b    = 1'b1;
                        n_state         = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (i_sts.over) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_OVERFLOW;
                    n_state           = S_DONE;
                end else if (i_sts.walk_end) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_OK;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/gda_dpath.sv =====
// gda_dpath: operand registers, year mod 25 reduction, day walker and result register
// depends on gda_pkg for types, codes and calendar helpers
`timescale 1ns / 1ps

module gda_dpath #(
    parameter int MAX_YEAR   = 9999,
    parameter int COUNT_BITS = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gda_pkg::t_in  i_item,
    input  gda_pkg::t_cmd i_cmd,
    output gda_pkg::t_sts o_sts,
    output logic          o_valid,
    input  logic          i_stall,
    output gda_pkg::t_out o_result
);
    import gda_pkg::*;

    localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);
    localparam logic [COUNT_BITS-1:0] CNT_ALL = '1;

    // captured operands
    logic                  r_kind;
    logic [4:0]            r_day_a;
    logic [3:0]            r_month_a;
    logic [13:0]           r_year_a;
    logic [4:0]            r_day_b;
    logic [3:0]            r_month_b;
    logic [13:0]           r_year_b;
    logic [COUNT_BITS-1:0] r_cnt;

    // year mod 25 reduction
    logic [REM_W-1:0] r_rem_a;
    logic [REM_W-1:0] r_rem_b;
    logic [3:0]       r_step;
    logic [REM_W-1:0] sub_val;

    // walking date
    logic [4:0]        r_d;
    logic [3:0]        r_m;
    logic [YEAR_W-1:0] r_y;
    logic [4:0]        r_y25;

    logic [1:0] r_st;
    logic       r_out_valid;
    t_out       r_out;
    t_out       n_out;

    logic                     leap_a;
    logic                     leap_b;
    logic                     leap_w;
    logic                     ok_a;
    logic                     ok_b;
    logic [4:0]               len_w;
    logic [COUNT_BITS+21:0]   cnt_ext;
    logic [COUNT_BITS+21:0]   diff_ext;
    logic                     at_a;

    assign sub_val = MOD_BASE << r_step;

    // date validity checks
    assign leap_a = is_leap(r_year_a[3:0], r_rem_a[4:0]);
    assign leap_b = is_leap(r_year_b[3:0], r_rem_b[4:0]);
    assign ok_a   = (r_day_a != 5'd0) && (r_month_a != 4'd0) && (r_month_a <= MONTH_DEC)
                  && (r_year_a != 14'd0) && (YEAR_W'(r_year_a) <= MAX_Y)
                  && (r_day_a <= month_len(r_month_a, leap_a));
    assign ok_b   = (r_day_b != 5'd0) && (r_month_b != 4'd0) && (r_month_b <= MONTH_DEC)
                  && (r_year_b != 14'd0) && (YEAR_W'(r_year_b) <= MAX_Y)
                  && (r_day_b <= month_len(r_month_b, leap_b));

    // walker month length and arrival test
    assign leap_w = is_leap(r_y[3:0], r_y25);
    assign len_w  = month_len(r_m, leap_w);
    assign at_a   = (r_d == r_day_a) && (r_m == r_month_a) && (r_y == YEAR_W'(r_year_a));

    assign cnt_ext  = (COUNT_BITS + 22)'(i_item.count);
    assign diff_ext = (COUNT_BITS + 22)'(r_cnt);

    // status to the controller
    always_comb begin
        o_sts             = '0;
        o_sts.kind        = r_kind;
        o_sts.reduce_last = (r_step == 4'd0);
        o_sts.ok_a        = ok_a;
        o_sts.ok_b        = ok_b;
        o_sts.b_later     = {r_year_b, r_month_b, r_day_b} > {r_year_a, r_month_a, r_day_a};
        o_sts.walk_end    = (r_kind == KIND_ADD) ? (r_cnt == '0) : at_a;
        o_sts.over        = (r_kind == KIND_ADD) && (r_y > MAX_Y);
        o_sts.out_free    = !r_out_valid || !i_stall;
    end

    // operand capture and mod 25 reduction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_item.kind;
            r_day_a   <= i_item.day_a;
            r_month_a <= i_item.month_a;
            r_year_a  <= i_item.year_a;
            r_day_b   <= i_item.day_b;
            r_month_b <= i_item.month_b;
            r_year_b  <= i_item.year_b;
            r_rem_a   <= i_item.year_a;
            r_rem_b   <= i_item.year_b;
            r_step    <= RED_TOP;
        end else if (i_cmd.reduce) begin
            if (r_rem_a >= sub_val) begin
                r_rem_a <= r_rem_a - sub_val;
            end
            if (r_rem_b >= sub_val) begin
                r_rem_b <= r_rem_b - sub_val;
            end
            if (r_step != 4'd0) begin
                r_step <= r_step - 4'd1;
            end
        end
    end

    // day walker and day counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt <= cnt_ext[COUNT_BITS-1:0];
        end else if (i_cmd.init_walk) begin
            if (i_cmd.from_b) begin
                r_d   <= r_day_b;
                r_m   <= r_month_b;
                r_y   <= YEAR_W'(r_year_b);
                r_y25 <= r_rem_b[4:0];
                r_cnt <= '0;
            end else begin
                r_d   <= r_day_a;
                r_m   <= r_month_a;
                r_y   <= YEAR_W'(r_year_a);
                r_y25 <= r_rem_a[4:0];
            end
        end else if (i_cmd.step) begin
            if (r_d >= len_w) begin
                r_d <= 5'd1;
                if (r_m == MONTH_DEC) begin
                    r_m   <= 4'd1;
                    r_y   <= r_y + YEAR_W'(1);
                    r_y25 <= (r_y25 == 5'd24) ? 5'd0 : r_y25 + 5'd1;
                end else begin
                    r_m <= r_m + 4'd1;
                end
            end else begin
                r_d <= r_d + 5'd1;
            end
            if (r_kind == KIND_ADD) begin
                r_cnt <= r_cnt - COUNT_BITS'(1);
            end else if (r_cnt != CNT_ALL) begin
                r_cnt <= r_cnt + COUNT_BITS'(1);
            end
        end
    end

    // final status
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_st <= i_cmd.status_code;
        end
    end

    // result contents, zero outside the fields that the status allows
    always_comb begin
        n_out        = '0;
        n_out.status = r_st;
        if (r_st == ST_OK) begin
            if (r_kind == KIND_ADD) begin
                n_out.res_day   = r_d;
                n_out.res_month = r_m;
                n_out.res_year  = r_y[13:0];
            end else begin
                n_out.days_between = diff_ext[21:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/core/gregorian_date_add_and_difference.sv =====
// gregorian_date_add_and_difference: top level of the calendar date arithmetic block
// depends on gda_pkg, gda_ctrl and gda_dpath
//
// usage:
//   input channel i_valid / o_stall / i_item carries one transaction: kind, date a,
//   date b and a day count. add mode advances date a by count days, difference
//   mode counts the days from date b up to date a.
//   output channel o_valid / i_stall / o_result returns exactly one result per
//   transaction with a status: ok, invalid date, b later than a, year overflow.
// sequencing:
//   one transaction at a time: year mod 25 reduction, a check step, then the
//   day stepper walks one day per cycle, then the result register is loaded;
//   the run time grows with count in add mode and with the days walked in
//   difference mode. invalid date and b later results skip the walk.
// reset:
//   synchronous active low; the sequencer returns to idle and the result
//   register is emptied.
// stalls:
//   the result register holds while i_stall is high; a new transaction is
//   taken meanwhile, but its result waits until the register is free.
`timescale 1ns / 1ps

module gregorian_date_add_and_difference #(
    parameter int MAX_YEAR   = 9999,
    parameter int COUNT_BITS = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  gda_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output gda_pkg::t_out o_result
);
    import gda_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    gda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath
    gda_dpath #(
        .MAX_YEAR   (MAX_YEAR),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule
